// File: hdl/pptg_pkg.sv
// Package for the primitive Pythagorean triple generator.
// Holds widths, the limit mask, control codes, the microcode ROM and the
// structs passed between the sequencer and the datapath. No dependencies.
`default_nettype none

package pptg_pkg;

    // Width of the limit as used by the search (low bits of the register).
    localparam int LIMIT_BITS = 32;
    localparam int LIM_W      = 32;
    localparam logic [LIM_W-1:0] LIMIT_MASK =
        (LIMIT_BITS >= LIM_W) ? {LIM_W{1'b1}} :
        LIM_W'((64'd1 << LIMIT_BITS) - 64'd1);

    localparam int V_W    = 16;   // outer value v, never above 46341
    localparam int U_W    = 17;   // inner value u, never above 65536
    localparam int PROD_W = 2 * U_W;
    localparam int SIDE_W = 32;

    // Datapath actions, one per microcode step.
    typedef enum logic [3:0] {
        ACT_NOP,
        ACT_MUL_VV,
        ACT_MUL_UU,
        ACT_ADV_U,
        ACT_GCD_STEP,
        ACT_MUL_UV,
        ACT_EMIT_FOUND,
        ACT_SET_EXH,
        ACT_NEXT_V,
        ACT_EMIT_NONE
    } t_act;

    // Jump conditions.
    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_EXH,
        COND_V_OVER,
        COND_U_OVER,
        COND_PARITY,
        COND_GCD_BUSY,
        COND_NOT_COPRIME,
        COND_OUT_BLOCKED
    } t_cond;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    typedef logic [3:0] t_pc;

    // Program addresses.
    localparam t_pc PC_CHK  = 4'd0;
    localparam t_pc PC_VV   = 4'd1;
    localparam t_pc PC_TV   = 4'd2;
    localparam t_pc PC_UU   = 4'd3;
    localparam t_pc PC_TU   = 4'd4;
    localparam t_pc PC_ADV  = 4'd5;
    localparam t_pc PC_GCD  = 4'd6;
    localparam t_pc PC_COP  = 4'd7;
    localparam t_pc PC_UV   = 4'd8;
    localparam t_pc PC_EMT  = 4'd9;
    localparam t_pc PC_SETX = 4'd10;
    localparam t_pc PC_NXV  = 4'd11;
    localparam t_pc PC_NF   = 4'd12;
    localparam t_pc PC_LAST = PC_NF;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_pc   target;
        logic  last;     // end of request when the jump is not taken
    } t_uop;

    // Status flags from the datapath, tested by the jump conditions.
    typedef struct packed {
        logic exh;
        logic v_over;
        logic u_over;
        logic parity;
        logic gcd_busy;
        logic not_coprime;
        logic out_blocked;
    } t_flags;

    function automatic t_uop uop_rom(input t_pc pc);
        t_uop w;
        case (pc)
            PC_CHK:  w = '{ACT_NOP,        COND_EXH,         PC_NF,   1'b0};
            PC_VV:   w = '{ACT_MUL_VV,     COND_NEVER,       PC_CHK,  1'b0};
            PC_TV:   w = '{ACT_NOP,        COND_V_OVER,      PC_SETX, 1'b0};
            PC_UU:   w = '{ACT_MUL_UU,     COND_NEVER,       PC_CHK,  1'b0};
            PC_TU:   w = '{ACT_NOP,        COND_U_OVER,      PC_NXV,  1'b0};
            PC_ADV:  w = '{ACT_ADV_U,      COND_PARITY,      PC_UU,   1'b0};
            PC_GCD:  w = '{ACT_GCD_STEP,   COND_GCD_BUSY,    PC_GCD,  1'b0};
            PC_COP:  w = '{ACT_NOP,        COND_NOT_COPRIME, PC_UU,   1'b0};
            PC_UV:   w = '{ACT_MUL_UV,     COND_NEVER,       PC_CHK,  1'b0};
            PC_EMT:  w = '{ACT_EMIT_FOUND, COND_OUT_BLOCKED, PC_EMT,  1'b1};
            PC_SETX: w = '{ACT_SET_EXH,    COND_ALWAYS,      PC_NF,   1'b0};
            PC_NXV:  w = '{ACT_NEXT_V,     COND_ALWAYS,      PC_VV,   1'b0};
            PC_NF:   w = '{ACT_EMIT_NONE,  COND_OUT_BLOCKED, PC_NF,   1'b1};
            default: w = '{ACT_NOP,        COND_NEVER,       PC_CHK,  1'b1};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: hdl/pptg_seq.sv
// Microcode sequencer: step counter, ROM read and conditional jumps.
// Depends on pptg_pkg for the ROM, the action and condition codes.
`default_nettype none

module pptg_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire pptg_pkg::t_flags  i_flags,
    output pptg_pkg::t_act         o_act,
    output logic                   o_busy
);

    pptg_pkg::t_seq_state r_state, n_state;
    pptg_pkg::t_pc        r_pc, n_pc;
    pptg_pkg::t_uop       w_uop;
    logic                 w_taken;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pptg_pkg::SEQ_IDLE;
            r_pc    <= pptg_pkg::PC_CHK;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    always_comb begin
        w_uop = pptg_pkg::uop_rom(r_pc);
        case (w_uop.cond)
            pptg_pkg::COND_NEVER:       w_taken = 1'b0;
            pptg_pkg::COND_ALWAYS:      w_taken = 1'b1;
            pptg_pkg::COND_EXH:         w_taken = i_flags.exh;
            pptg_pkg::COND_V_OVER:      w_taken = i_flags.v_over;
            pptg_pkg::COND_U_OVER:      w_taken = i_flags.u_over;
            pptg_pkg::COND_PARITY:      w_taken = i_flags.parity;
            pptg_pkg::COND_GCD_BUSY:    w_taken = i_flags.gcd_busy;
            pptg_pkg::COND_NOT_COPRIME: w_taken = i_flags.not_coprime;
            pptg_pkg::COND_OUT_BLOCKED: w_taken = i_flags.out_blocked;
            default:                    w_taken = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        o_act   = pptg_pkg::ACT_NOP;
        case (r_state)
            pptg_pkg::SEQ_IDLE: begin
                if (i_start) begin
                    n_state = pptg_pkg::SEQ_RUN;
                    n_pc    = pptg_pkg::PC_CHK;
                end
            end
            pptg_pkg::SEQ_RUN: begin
                o_act = w_uop.act;
                if (w_taken) begin
                    n_pc = w_uop.target;
                end else if (w_uop.last) begin
                    n_state = pptg_pkg::SEQ_IDLE;
                end else begin
                    n_pc = pptg_pkg::t_pc'(r_pc + 4'd1);
                end
            end
            default: begin
                n_state = pptg_pkg::SEQ_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state == pptg_pkg::SEQ_RUN);

    a_pc_in_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pptg_pkg::SEQ_RUN) |-> (r_pc <= pptg_pkg::PC_LAST))
        else $error("step counter left the program");

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == pptg_pkg::SEQ_IDLE))
        else $error("request started while the sequencer was busy");

    a_emit_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == pptg_pkg::SEQ_RUN) && (w_uop.act == pptg_pkg::ACT_EMIT_FOUND)
         && !i_flags.out_blocked) |=> (r_state == pptg_pkg::SEQ_IDLE))
        else $error("sequencer did not finish after emitting a triple");

endmodule

`default_nettype wire

// File: hdl/pptg_dp.sv
// Datapath: pair registers, shared multiplier, binary gcd, bound tests
// and the output register. Depends on pptg_pkg; driven by pptg_seq.
`default_nettype none

module pptg_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic                        i_restart,
    input  wire logic                        i_cfg_we,
    input  wire logic [pptg_pkg::LIM_W-1:0]  i_cfg_wdata,
    input  wire pptg_pkg::t_act              i_act,
    output pptg_pkg::t_flags                 o_flags,
    input  wire logic                        i_out_stall,
    output logic                             o_out_valid,
    output logic [pptg_pkg::SIDE_W-1:0]      o_side_a,
    output logic [pptg_pkg::SIDE_W-1:0]      o_side_b,
    output logic [pptg_pkg::SIDE_W-1:0]      o_side_c,
    output logic                             o_found
);

    localparam int V_W    = pptg_pkg::V_W;
    localparam int U_W    = pptg_pkg::U_W;
    localparam int PROD_W = pptg_pkg::PROD_W;
    localparam int LIM_W  = pptg_pkg::LIM_W;
    localparam int SIDE_W = pptg_pkg::SIDE_W;

    // Control state
    logic [LIM_W-1:0]  r_limit, n_limit;
    logic [V_W-1:0]    r_v, n_v;
    logic [U_W-1:0]    r_u, n_u;
    logic              r_exh, n_exh;
    logic              r_out_valid, n_out_valid;

    // Working and result registers
    logic [2*V_W-1:0]  r_sq_v, n_sq_v;
    logic [PROD_W-1:0] r_sq_u, n_sq_u;
    logic [U_W-1:0]    r_tu, n_tu;
    logic [U_W-1:0]    r_gx, n_gx;
    logic [U_W-1:0]    r_gy, n_gy;
    logic [SIDE_W-1:0] r_p, n_p;
    logic [SIDE_W-1:0] r_a, n_a;
    logic [SIDE_W-1:0] r_c, n_c;
    logic [SIDE_W-1:0] r_side_a, n_side_a;
    logic [SIDE_W-1:0] r_side_b, n_side_b;
    logic [SIDE_W-1:0] r_side_c, n_side_c;
    logic              r_found, n_found;

    logic [U_W-1:0]    w_opa, w_opb;
    logic [PROD_W-1:0] w_prod;
    logic [PROD_W:0]   w_usum;
    logic [SIDE_W-1:0] w_b;
    logic              w_blocked;

    // Shared multiplier; its product is registered by every step that uses it.
    always_comb begin
        case (i_act)
            pptg_pkg::ACT_MUL_VV: begin
                w_opa = {1'b0, r_v};
                w_opb = {1'b0, r_v};
            end
            pptg_pkg::ACT_MUL_UU: begin
                w_opa = r_u;
                w_opb = r_u;
            end
            default: begin
                w_opa = r_tu;
                w_opb = {1'b0, r_v};
            end
        endcase
        w_prod = PROD_W'(w_opa) * PROD_W'(w_opb);
    end

    assign w_usum    = {1'b0, r_sq_u} + (PROD_W+1)'(r_sq_v);
    assign w_blocked = r_out_valid && i_out_stall;
    assign w_b       = {r_p[SIDE_W-2:0], 1'b0};

    always_comb begin
        o_flags.exh         = r_exh;
        o_flags.v_over      = {r_sq_v, 1'b0} > (2*V_W+1)'(r_limit);
        o_flags.u_over      = w_usum > (PROD_W+1)'(r_limit);
        o_flags.parity      = (r_u[0] == r_v[0]);
        o_flags.gcd_busy    = (r_gx != '0) && (r_gy != '0);
        o_flags.not_coprime = ((r_gx | r_gy) != U_W'(1));
        o_flags.out_blocked = w_blocked;
    end

    always_comb begin
        n_limit     = r_limit;
        n_v         = r_v;
        n_u         = r_u;
        n_exh       = r_exh;
        n_out_valid = r_out_valid && i_out_stall;
        n_sq_v      = r_sq_v;
        n_sq_u      = r_sq_u;
        n_tu        = r_tu;
        n_gx        = r_gx;
        n_gy        = r_gy;
        n_p         = r_p;
        n_a         = r_a;
        n_c         = r_c;
        n_side_a    = r_side_a;
        n_side_b    = r_side_b;
        n_side_c    = r_side_c;
        n_found     = r_found;

        if (i_cfg_we) begin
            n_limit = i_cfg_wdata & pptg_pkg::LIMIT_MASK;
        end
        if (i_start && i_restart) begin
            n_v   = V_W'(1);
            n_u   = U_W'(2);
            n_exh = 1'b0;
        end

        case (i_act)
            pptg_pkg::ACT_MUL_VV: begin
                n_sq_v = w_prod[2*V_W-1:0];
            end
            pptg_pkg::ACT_MUL_UU: begin
                n_sq_u = w_prod;
            end
            pptg_pkg::ACT_ADV_U: begin
                n_tu = r_u;
                n_gx = r_u;
                n_gy = {1'b0, r_v};
                n_u  = U_W'(r_u + U_W'(1));
            end
            pptg_pkg::ACT_GCD_STEP: begin
                // binary gcd; a common factor of two is already ruled out
                if ((r_gx != '0) && (r_gy != '0)) begin
                    if (!r_gx[0]) begin
                        n_gx = r_gx >> 1;
                    end else if (!r_gy[0]) begin
                        n_gy = r_gy >> 1;
                    end else if (r_gx >= r_gy) begin
                        n_gx = r_gx - r_gy;
                    end else begin
                        n_gy = r_gy - r_gx;
                    end
                end
            end
            pptg_pkg::ACT_MUL_UV: begin
                n_p = w_prod[SIDE_W-1:0];
                n_a = SIDE_W'(r_sq_u - PROD_W'(r_sq_v));
                n_c = w_usum[SIDE_W-1:0];
            end
            pptg_pkg::ACT_EMIT_FOUND: begin
                if (!w_blocked) begin
                    n_out_valid = 1'b1;
                    n_found     = 1'b1;
                    n_side_c    = r_c;
                    if (r_a > w_b) begin
                        n_side_a = w_b;
                        n_side_b = r_a;
                    end else begin
                        n_side_a = r_a;
                        n_side_b = w_b;
                    end
                end
            end
            pptg_pkg::ACT_SET_EXH: begin
                n_exh = 1'b1;
            end
            pptg_pkg::ACT_NEXT_V: begin
                n_v = V_W'(r_v + V_W'(1));
                n_u = U_W'({1'b0, r_v} + U_W'(2));
            end
            pptg_pkg::ACT_EMIT_NONE: begin
                if (!w_blocked) begin
                    n_out_valid = 1'b1;
                    n_found     = 1'b0;
                    n_side_a    = '0;
                    n_side_b    = '0;
                    n_side_c    = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= '0;
            r_v         <= V_W'(1);
            r_u         <= U_W'(2);
            r_exh       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_limit     <= n_limit;
            r_v         <= n_v;
            r_u         <= n_u;
            r_exh       <= n_exh;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_v   <= n_sq_v;
        r_sq_u   <= n_sq_u;
        r_tu     <= n_tu;
        r_gx     <= n_gx;
        r_gy     <= n_gy;
        r_p      <= n_p;
        r_a      <= n_a;
        r_c      <= n_c;
        r_side_a <= n_side_a;
        r_side_b <= n_side_b;
        r_side_c <= n_side_c;
        r_found  <= n_found;
    end

    assign o_out_valid = r_out_valid;
    assign o_side_a    = r_side_a;
    assign o_side_b    = r_side_b;
    assign o_side_c    = r_side_c;
    assign o_found     = r_found;

    a_legs_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_found) |-> (r_side_a <= r_side_b))
        else $error("legs of a found triple are out of order");

    a_none_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_found) |->
        ((r_side_a == '0) && (r_side_b == '0) && (r_side_c == '0)))
        else $error("not-found result carries non-zero sides");

    a_u_above_v: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_u > {1'b0, r_v})
        else $error("inner value fell to or below outer value");

endmodule

`default_nettype wire

// File: hdl/primitive_pythagorean_triple_gen_core.sv
// Top level of the primitive Pythagorean triple generator.
// Instantiates pptg_seq (microcode sequencer) and pptg_dp (datapath); uses pptg_pkg.
//
// Input channel (i_in_valid / o_in_stall / i_restart): each request asks for the
// next primitive triple with every side at most the limit; i_restart restarts the
// walk at v=1, u=2, otherwise carry on from the stored pair.
// Output channel (o_out_valid / i_out_stall): one result per request; o_found = 1
// gives legs a <= b and hypotenuse c, o_found = 0 means the walk ran out and the
// sides are zero until a restart. i_cfg_we writes i_cfg_wdata into the limit;
// write only while idle.
// One request at a time: o_in_stall is high while the sequencer runs. A request
// checks the exhausted flag, squares v and tests the v bound, then squares u and
// tests the u bound; a pair of equal parity is dropped, a pair past the u bound
// moves to the next outer value, and any other pair runs the binary gcd one step
// at a time; a coprime pair forms the sides and is emitted, and the result is
// valid the cycle after the emit. The multiplier is shared, one product per step.
// Reset clears the limit to 0 and the walk to v=1, u=2. A result waits in the
// output register while i_out_stall is high; a new request may still be taken,
// and its search runs until it must emit, then holds.
`default_nettype none

module primitive_pythagorean_triple_gen_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // request channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_restart,
    // result channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [pptg_pkg::SIDE_W-1:0]      o_side_a,
    output logic [pptg_pkg::SIDE_W-1:0]      o_side_b,
    output logic [pptg_pkg::SIDE_W-1:0]      o_side_c,
    output logic                             o_found,
    // limit register
    input  wire logic                        i_cfg_we,
    input  wire logic [pptg_pkg::LIM_W-1:0]  i_cfg_wdata
);

    logic              w_busy;
    logic              w_start;
    pptg_pkg::t_act    w_act;
    pptg_pkg::t_flags  w_flags;

    // Take a request only while the sequencer is idle.
    assign o_in_stall = w_busy;
    assign w_start    = i_in_valid && !w_busy;

    pptg_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_flags (w_flags),
        .o_act   (w_act),
        .o_busy  (w_busy)
    );

    pptg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_restart   (i_restart),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_act       (w_act),
        .o_flags     (w_flags),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_side_a    (o_side_a),
        .o_side_b    (o_side_b),
        .o_side_c    (o_side_c),
        .o_found     (o_found)
    );

endmodule

`default_nettype wire
